@@ sv/sat_pkg.sv @@
// shared types and constants of the sampled allocation tracker
package sat_pkg;

  localparam int unsigned TABLE_SLOTS = 4096;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned SIZE_W      = 48;
  localparam int unsigned THRESH_W    = 49;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned CNT_W       = 50;
  localparam int unsigned SLOT_W      = 12;
  localparam int unsigned HASH_SHIFT  = 16;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } sat_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } sat_state_e;

  typedef struct packed {
    sat_op_e               opcode;
    logic [ADDR_W-1:0]     address;
    logic [SIZE_W-1:0]     alloc_size;
    logic [THRESH_W-1:0]   next_threshold;
    logic                  force_sample;
    logic [TIME_W-1:0]     timestamp;
  } sat_in_t;

  typedef struct packed {
    logic              sampled;
    logic              inserted;
    logic              table_full;
    logic              removed;
    logic [SLOT_W-1:0] slot_index;
  } sat_out_t;

endpackage

@@ sv/sampled_allocation_tracker.sv @@
// sampled allocation tracker: countdown sampler and linear-probe address table
// an ignored or unsampled word goes from accept to the done state and the output register;
//   a sampled allocation or a free passes the hash state, then probes slots in turn
// the hash is masked for a power-of-two slot count, else folded by digits; one word
//   in flight at a time, set by the single probe port of the table
// reset starts a clearing pass over every table slot; input is stalled
module sampled_allocation_tracker #(
  parameter int unsigned TableSlots = sat_pkg::TABLE_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sat_pkg::sat_in_t in_data_i,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sat_pkg::sat_out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(TableSlots);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSlots - 1);
  localparam int unsigned PayW = sat_pkg::SIZE_W + sat_pkg::TIME_W;

  sat_pkg::sat_state_e state_q, state_d;

  logic                            enabled_q;
  logic signed [sat_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic signed [sat_pkg::CNT_W-1:0] diff;
  logic                            take;
  logic                            accept;
  logic                            active;

  sat_pkg::sat_in_t  item_q, item_d;
  sat_pkg::sat_out_t res_q, res_d;
  sat_pkg::sat_out_t out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] probes_q, probes_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [IdxW+sat_pkg::SLOT_W-1:0] idx_wide;

  logic                       bkt_start;
  logic                       bkt_done;
  logic [IdxW-1:0]            bkt_idx;

  logic                       wr_en;
  logic [IdxW-1:0]            wr_addr;
  logic [sat_pkg::ADDR_W-1:0] wr_data;
  logic [sat_pkg::ADDR_W-1:0] rd_data;
  logic                       pay_we;

  logic is_free;
  logic slot_empty;
  logic slot_match;
  logic probe_last;
  logic probe_end;

  assign diff = cnt_q - $signed({{(sat_pkg::CNT_W - sat_pkg::SIZE_W){1'b0}},
                                 in_data_i.alloc_size});
  assign take = in_data_i.force_sample || diff[sat_pkg::CNT_W-1] || (diff == '0);
  assign accept = (state_q == sat_pkg::ST_IDLE) && in_valid_i;
  assign active = enabled_q && (in_data_i.address != '0) &&
                  ((in_data_i.opcode == sat_pkg::OP_FREE) || take);
  assign bkt_start = accept && active;

  assign is_free    = (item_q.opcode == sat_pkg::OP_FREE);
  assign slot_empty = (rd_data == '0);
  assign slot_match = (rd_data == item_q.address);
  assign probe_last = (probes_q == LastIdx);
  assign probe_end  = slot_empty || (is_free && slot_match) || probe_last;
  assign idx_wide   = {{sat_pkg::SLOT_W{1'b0}}, idx_q};
  assign out_free   = !out_valid_q || !out_stall_i;

  sat_bucket #(
    .TableSlots (TableSlots)
  ) u_bucket (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bkt_start),
    .addr_i   (in_data_i.address),
    .done_o   (bkt_done),
    .bucket_o (bkt_idx)
  );

  sat_ram #(
    .Width (sat_pkg::ADDR_W),
    .Depth (TableSlots)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (idx_d),
    .rdata_o (rd_data)
  );

  sat_ram #(
    .Width (PayW),
    .Depth (TableSlots)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (idx_q),
    .wdata_i ({item_q.alloc_size, item_q.timestamp}),
    .raddr_i (idx_q),
    .rdata_o ()
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sat_pkg::ST_CLEAR: begin
        if (clr_q == LastIdx) state_d = sat_pkg::ST_IDLE;
      end
      sat_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = active ? sat_pkg::ST_HASH : sat_pkg::ST_DONE;
      end
      sat_pkg::ST_HASH: begin
        if (bkt_done) state_d = sat_pkg::ST_PROBE;
      end
      sat_pkg::ST_PROBE: begin
        if (probe_end) state_d = sat_pkg::ST_DONE;
      end
      sat_pkg::ST_DONE: begin
        if (out_free) state_d = sat_pkg::ST_IDLE;
      end
      default: state_d = sat_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    idx_d       = idx_q;
    probes_d    = probes_q;
    clr_d       = clr_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = '0;
    pay_we      = 1'b0;
    unique case (state_q)
      sat_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + IdxW'(1);
      end
      sat_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d  = '0;
          if (enabled_q && (in_data_i.address != '0) &&
              (in_data_i.opcode == sat_pkg::OP_ALLOC)) begin
            res_d.sampled = take;
            cnt_d = take ? $signed({{(sat_pkg::CNT_W - sat_pkg::THRESH_W){1'b0}},
                                    in_data_i.next_threshold})
                         : diff;
          end
        end
      end
      sat_pkg::ST_HASH: begin
        if (bkt_done) begin
          idx_d    = bkt_idx;
          probes_d = '0;
        end
      end
      sat_pkg::ST_PROBE: begin
        if (!is_free) begin
          if (slot_empty) begin
            wr_en            = 1'b1;
            wr_data          = item_q.address;
            pay_we           = 1'b1;
            res_d.inserted   = 1'b1;
            res_d.slot_index = idx_wide[sat_pkg::SLOT_W-1:0];
          end else if (probe_last) begin
            res_d.table_full = 1'b1;
          end
        end else if (!slot_empty && slot_match) begin
          wr_en            = 1'b1;
          res_d.removed    = 1'b1;
          res_d.slot_index = idx_wide[sat_pkg::SLOT_W-1:0];
        end
        if (!probe_end) begin
          idx_d    = (idx_q == LastIdx) ? '0 : idx_q + IdxW'(1);
          probes_d = probes_q + IdxW'(1);
        end
      end
      sat_pkg::ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sat_pkg::ST_CLEAR;
      enabled_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      if (cfg_we_i) begin
        enabled_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    res_q    <= res_d;
    out_q    <= out_d;
    idx_q    <= idx_d;
    probes_q <= probes_d;
  end

  assign in_stall_o  = (state_q != sat_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.inserted && out_data_o.table_full))
    else $error("insert and full reported together");

  a_store_sampled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.inserted || out_data_o.table_full) |-> out_data_o.sampled)
    else $error("table outcome without a sample");

  a_remove_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.removed |-> !out_data_o.sampled && !out_data_o.inserted)
    else $error("removal mixed with allocation outcome");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == sat_pkg::ST_CLEAR) || (state_q == sat_pkg::ST_PROBE))
    else $error("table written outside clear or probe");

  a_bucket_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bkt_done |-> (state_q == sat_pkg::ST_HASH))
    else $error("bucket ready while not hashing");
`endif

endmodule

@@ sv/sat_ram.sv @@
// generic single-write, single-read ram with registered read data
module sat_ram #(
  parameter int unsigned Width = sat_pkg::ADDR_W,
  parameter int unsigned Depth = sat_pkg::TABLE_SLOTS,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sat_bucket.sv @@
// home bucket unit: (a ^ (a >> 16)) mod slot count, folded by digits when not a power of two
module sat_bucket #(
  parameter int unsigned TableSlots = sat_pkg::TABLE_SLOTS,
  localparam int unsigned IdxW = $clog2(TableSlots)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sat_pkg::ADDR_W-1:0] addr_i,
  output logic                      done_o,
  output logic [IdxW-1:0]           bucket_o
);

  localparam bit SlotsPow2 = (TableSlots & (TableSlots - 1)) == 0;

  logic [sat_pkg::ADDR_W-1:0] key;

  assign key = addr_i ^ (addr_i >> sat_pkg::HASH_SHIFT);

  if (SlotsPow2) begin : g_mask
    logic [IdxW-1:0] bucket_q;
    logic            done_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bucket_q <= key[IdxW-1:0];
      end
    end

    assign done_o   = done_q;
    assign bucket_o = bucket_q;
  end else begin : g_fold
    localparam int unsigned DigW  = 16;
    localparam int unsigned ProdW = 2 * DigW;
    localparam int unsigned Steps = 2 * sat_pkg::ADDR_W / DigW;
    localparam int unsigned StepW = $clog2(Steps + 1);
    localparam logic [ProdW-1:0] SlotsC = ProdW'(TableSlots);
    localparam logic [ProdW-1:0] Recip  = ProdW'((64'd1 << ProdW) / TableSlots);

    logic [sat_pkg::ADDR_W-1:0] key_q;
    logic [DigW-1:0]            rem_q;
    logic [ProdW-1:0]           num;
    logic [2*ProdW-1:0]         prod;
    logic [ProdW-1:0]           num_q;
    logic [ProdW-1:0]           quot_q;
    logic [ProdW-1:0]           part;
    logic [ProdW-1:0]           fix;
    logic [StepW-1:0]           step_q;
    logic                       done_q;

    // per 16-bit digit: a reciprocal quotient estimate, then
    // a subtract and a correction by at most one slot count
    assign num  = {rem_q, key_q[sat_pkg::ADDR_W-1 -: DigW]};
    assign prod = {{ProdW{1'b0}}, num} * {{ProdW{1'b0}}, Recip};
    assign part = num_q - quot_q * SlotsC;
    assign fix  = (part >= SlotsC) ? part - SlotsC : part;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_q <= '0;
        done_q <= 1'b0;
      end else if (start_i) begin
        step_q <= StepW'(Steps);
        done_q <= 1'b0;
      end else if (step_q != '0) begin
        step_q <= step_q - StepW'(1);
        done_q <= (step_q == StepW'(1));
      end else begin
        done_q <= 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key;
        rem_q <= '0;
      end else if (step_q != '0) begin
        if (!step_q[0]) begin
          num_q  <= num;
          quot_q <= prod[2*ProdW-1:ProdW];
          key_q  <= key_q << DigW;
        end else begin
          rem_q <= fix[DigW-1:0];
        end
      end
    end

    assign done_o   = done_q;
    assign bucket_o = rem_q[IdxW-1:0];
  end

endmodule
